// ===== design/scrw_pkg.sv =====
// Shared types and constants for the session counter replay window unit.
`default_nettype none

package scrw_pkg;

  // Width of the seen-counter bitmap and of the window.
  localparam int unsigned BITMAP_W    = 64;
  localparam int unsigned WINDOW_SIZE = 64;
  localparam int unsigned BIT_IDX_W   = $clog2(BITMAP_W);

  localparam int unsigned COUNTER_W  = 64;
  localparam int unsigned RATCHET_W  = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Reset values of the configuration registers.
  localparam logic                  RATCHET_ENABLE_RST = 1'b1;
  localparam logic [RATCHET_W-1:0]  RATCHET_PERIOD_RST = 32'd1000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_RATCHET_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATCHET_PERIOD = 2'd1;

  // Item modes.
  typedef enum logic [1:0] {
    MODE_OPEN  = 2'd0,
    MODE_SEND  = 2'd1,
    MODE_RECV  = 2'd2,
    MODE_CLOSE = 2'd3
  } mode_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_REPLAY   = 2'd1,
    ST_NOT_OPEN = 2'd2
  } status_t;

  // Outcome of one receive check against the window.
  typedef struct packed {
    logic                 replay;
    logic [COUNTER_W-1:0] highest;
    logic [BITMAP_W-1:0]  bitmap;
  } window_upd_t;

endpackage

`default_nettype wire

// ===== design/scrw_window.sv =====
// Sliding-window replay check for one received counter.
`default_nettype none

module scrw_window (
  input  logic [scrw_pkg::COUNTER_W-1:0] highest,
  input  logic [scrw_pkg::BITMAP_W-1:0]  bitmap,
  input  logic [scrw_pkg::COUNTER_W-1:0] received_counter,
  output scrw_pkg::window_upd_t          upd
);
  import scrw_pkg::*;

  logic                 at_or_below;
  logic [COUNTER_W-1:0] behind;
  logic [COUNTER_W-1:0] ahead;
  logic                 in_window;
  logic                 far_ahead;
  logic [BIT_IDX_W-1:0] idx;
  logic [BITMAP_W-1:0]  mark;

  // Distance to the highest counter in both directions
  assign at_or_below = (received_counter <= highest);
  assign behind      = highest - received_counter;
  assign ahead       = received_counter - highest;
  assign in_window   = (behind < COUNTER_W'(WINDOW_SIZE));
  assign far_ahead   = (ahead >= COUNTER_W'(BITMAP_W));
  assign idx         = behind[BIT_IDX_W-1:0];
  assign mark        = {{(BITMAP_W-1){1'b0}}, 1'b1} << idx;

  // Check an old counter against the bitmap, or slide the window forward
  always_comb begin
    upd.replay  = 1'b0;
    upd.highest = highest;
    upd.bitmap  = bitmap;
    if (at_or_below) begin
      if (!in_window || ((bitmap & mark) != '0)) begin
        upd.replay = 1'b1;
      end else begin
        upd.bitmap = bitmap | mark;
      end
    end else begin
      upd.highest = received_counter;
      if (far_ahead) begin
        upd.bitmap = {{(BITMAP_W-1){1'b0}}, 1'b1};
      end else begin
        upd.bitmap = (bitmap << ahead[BIT_IDX_W-1:0]) | {{(BITMAP_W-1){1'b0}}, 1'b1};
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/session_counter_replay_window_unit.sv =====
// Top level of the session counter replay window unit.
//
// Usage:
//   Input channel (in_valid/in_ready) carries mode and received_counter.
//   Open starts a fresh session, send hands out the next send counter and
//   flags a due key ratchet, receive runs the 64-entry anti-replay window,
//   close clears the session. Every input transaction yields exactly one
//   result transaction on out_valid/out_ready (status, assigned_counter,
//   ratchet_due).
//   An accepted item waits in the input register and then loads the result
//   register, from which its result can be taken. Throughput: one item per
//   cycle while out_ready stays high; the session state is updated in the
//   same cycle that loads the result register, so the next item sees it at once.
//   Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
//   ready; index 0 enables the ratchet, index 1 sets the ratchet period,
//   other indexes are ignored. Write it only while no item is in flight.
//   Reset: session closed, all counters and the bitmap zero, ratchet
//   enabled with a period of 1000, both pipeline registers empty.
//   Stall: while out_ready is low the result is held; one more item can
//   wait in the input register, after which in_ready drops.
`default_nettype none

module session_counter_replay_window_unit (
  input  logic                             clk,
  input  logic                             rst,
  // input channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       mode,
  input  logic [scrw_pkg::COUNTER_W-1:0]   received_counter,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       status,
  output logic [scrw_pkg::COUNTER_W-1:0]   assigned_counter,
  output logic                             ratchet_due,
  // configuration channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [scrw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [scrw_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import scrw_pkg::*;

  // Configuration registers
  logic                 ratchet_enable;
  logic [RATCHET_W-1:0] ratchet_period;

  // Input register
  logic                 item_valid;
  mode_t                item_mode;
  logic [COUNTER_W-1:0] item_counter;

  // Session state
  logic                 session_open, session_open_next;
  logic [COUNTER_W-1:0] next_send_counter, next_send_counter_next;
  logic [COUNTER_W-1:0] highest_received, highest_received_next;
  logic [BITMAP_W-1:0]  seen_bitmap, seen_bitmap_next;
  logic [RATCHET_W-1:0] sends_since_ratchet, sends_since_ratchet_next;

  // Result values for the item in the input register
  status_t              res_status;
  logic [COUNTER_W-1:0] res_assigned;
  logic                 res_due;

  logic                 advance;
  logic [RATCHET_W-1:0] sends_inc;
  window_upd_t          win;

  // Move the held item into the result register when that register frees up
  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;
  assign cfg_ready = 1'b1;

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ratchet_enable <= RATCHET_ENABLE_RST;
      ratchet_period <= RATCHET_PERIOD_RST;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_RATCHET_ENABLE) begin
        ratchet_enable <= cfg_data[0];
      end else if (cfg_index == CFG_RATCHET_PERIOD) begin
        ratchet_period <= cfg_data[RATCHET_W-1:0];
      end
    end
  end

  // Capture the input transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_mode    <= mode_t'(mode);
      item_counter <= received_counter;
    end
  end

  // Replay window check for a receive
  scrw_window u_window (
    .highest          (highest_received),
    .bitmap           (seen_bitmap),
    .received_counter (item_counter),
    .upd              (win)
  );

  assign sends_inc = sends_since_ratchet + RATCHET_W'(1);

  // Compute the result and the session update for the held item
  always_comb begin
    session_open_next        = session_open;
    next_send_counter_next   = next_send_counter;
    highest_received_next    = highest_received;
    seen_bitmap_next         = seen_bitmap;
    sends_since_ratchet_next = sends_since_ratchet;
    res_status               = ST_OK;
    res_assigned             = '0;
    res_due                  = 1'b0;
    if (advance) begin
      case (item_mode)
        MODE_OPEN, MODE_CLOSE: begin
          session_open_next        = (item_mode == MODE_OPEN);
          next_send_counter_next   = '0;
          highest_received_next    = '0;
          seen_bitmap_next         = '0;
          sends_since_ratchet_next = '0;
        end
        MODE_SEND: begin
          if (!session_open) begin
            res_status = ST_NOT_OPEN;
          end else begin
            res_assigned             = next_send_counter;
            next_send_counter_next   = next_send_counter + COUNTER_W'(1);
            sends_since_ratchet_next = sends_inc;
            if (ratchet_enable && (sends_inc >= ratchet_period)) begin
              res_due                  = 1'b1;
              sends_since_ratchet_next = '0;
            end
          end
        end
        MODE_RECV: begin
          if (!session_open) begin
            res_status = ST_NOT_OPEN;
          end else if (win.replay) begin
            res_status = ST_REPLAY;
          end else begin
            highest_received_next = win.highest;
            seen_bitmap_next      = win.bitmap;
          end
        end
        default: begin
          res_status = ST_OK;
        end
      endcase
    end
  end

  // Update the session state
  always_ff @(posedge clk) begin
    if (rst) begin
      session_open        <= 1'b0;
      next_send_counter   <= '0;
      highest_received    <= '0;
      seen_bitmap         <= '0;
      sends_since_ratchet <= '0;
    end else begin
      session_open        <= session_open_next;
      next_send_counter   <= next_send_counter_next;
      highest_received    <= highest_received_next;
      seen_bitmap         <= seen_bitmap_next;
      sends_since_ratchet <= sends_since_ratchet_next;
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status           <= res_status;
      assigned_counter <= res_assigned;
      ratchet_due      <= res_due;
    end
  end

endmodule

`default_nettype wire

// ===== design/scrw_checker.sv =====
// Port-level checks for the session counter replay window unit, with bind.
`default_nettype none

module scrw_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [1:0]                      status,
  input logic [scrw_pkg::COUNTER_W-1:0]  assigned_counter,
  input logic                            ratchet_due
);
  import scrw_pkg::*;

  // No result may come out of reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result transaction keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) &&
      $stable(assigned_counter) && $stable(ratchet_due))
    else $error("stalled result changed");

  // A failed item never hands out a counter or a ratchet
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> (assigned_counter == '0) && !ratchet_due)
    else $error("failed item carries a counter or ratchet flag");

  // A ratchet is only signalled on a successful send
  a_due_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && ratchet_due |-> (status == ST_OK))
    else $error("ratchet flagged on a failed item");

endmodule

bind session_counter_replay_window_unit scrw_checker u_scrw_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .status           (status),
  .assigned_counter (assigned_counter),
  .ratchet_due      (ratchet_due)
);

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for the session counter replay window unit.
`timescale 1ns / 100ps

module testbench;
  import scrw_pkg::*;

  // Spare register index: the block must ignore writes to it.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd2;

  typedef struct {
    status_t              status;
    logic [COUNTER_W-1:0] assigned;
    logic                 due;
  } outcome_t;

  // Session tracker: mirrors the block's state and configuration, predicts
  // the outcome of every accepted transaction and checks results in order.
  class session_tracker;
    logic                 ratchet_on;
    logic [RATCHET_W-1:0] ratchet_every;
    logic                 is_open;
    logic [COUNTER_W-1:0] send_ctr;
    logic [COUNTER_W-1:0] highest_rx;
    logic [BITMAP_W-1:0]  seen;
    logic [RATCHET_W-1:0] sends_since;
    outcome_t             expected_q[$];
    int errors, items, results, n_send, n_recv, n_replay, n_ratchet, n_closed;

    function new();
      ratchet_on    = RATCHET_ENABLE_RST;
      ratchet_every = RATCHET_PERIOD_RST;
      clear_session();
    endfunction

    function void clear_session();
      is_open     = 1'b0;
      send_ctr    = '0;
      highest_rx  = '0;
      seen        = '0;
      sends_since = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_RATCHET_ENABLE) ratchet_on = data[0];
      else if (idx == CFG_RATCHET_PERIOD) ratchet_every = data;
    endfunction

    // Run the sliding-window check and update the window on success.
    function status_t window_check(logic [COUNTER_W-1:0] ctr);
      logic [COUNTER_W-1:0] gap;
      if (ctr <= highest_rx) begin
        gap = highest_rx - ctr;
        if (gap >= WINDOW_SIZE) return ST_REPLAY;
        if (seen[gap[BIT_IDX_W-1:0]]) return ST_REPLAY;
        seen[gap[BIT_IDX_W-1:0]] = 1'b1;
      end else begin
        gap = ctr - highest_rx;
        seen = (gap >= BITMAP_W) ? 64'd1 : ((seen << gap) | 64'd1);
        highest_rx = ctr;
      end
      return ST_OK;
    endfunction

    function void accept_item(mode_t m, logic [COUNTER_W-1:0] ctr);
      outcome_t o;
      o.status   = ST_OK;
      o.assigned = '0;
      o.due      = 1'b0;
      items++;
      case (m)
        MODE_OPEN: begin
          clear_session();
          is_open = 1'b1;
        end
        MODE_CLOSE: begin
          clear_session();
        end
        default: begin
          if (!is_open) begin
            o.status = ST_NOT_OPEN;
            n_closed++;
          end else if (m == MODE_SEND) begin
            n_send++;
            o.assigned  = send_ctr;
            send_ctr    = send_ctr + 1'b1;
            sends_since = sends_since + 1'b1;
            if (ratchet_on && sends_since >= ratchet_every) begin
              o.due       = 1'b1;
              sends_since = '0;
              n_ratchet++;
            end
          end else begin
            n_recv++;
            o.status = window_check(ctr);
            if (o.status == ST_REPLAY) n_replay++;
          end
        end
      endcase
      expected_q.push_back(o);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task flag_mismatch(string msg);
      errors++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task check_outcome(logic [1:0] st, logic [COUNTER_W-1:0] ac, logic due);
      outcome_t o;
      results++;
      if (expected_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result status=%0d counter=%0h due=%0b",
                                st, ac, due));
      end else begin
        o = expected_q.pop_front();
        if (st !== o.status || ac !== o.assigned || due !== o.due)
          flag_mismatch($sformatf("result %0d: got status=%0d counter=%0h due=%0b, want %0d %0h %0b",
                                  results, st, ac, due, o.status, o.assigned, o.due));
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            mode = '0;
  logic [COUNTER_W-1:0]  received_counter = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [1:0]            status;
  logic [COUNTER_W-1:0]  assigned_counter;
  logic                  ratchet_due;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int src_idle  = 0;
  int stall_pct = 0;
  int settings  = 0;
  session_tracker tracker;

  session_counter_replay_window_unit dut (
    .clk, .rst,
    .in_valid, .in_ready, .mode, .received_counter,
    .out_valid, .out_ready, .status, .assigned_counter, .ratchet_due,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #5 clk = ~clk;

  // Check each result transaction and pick the next stall state.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      tracker.check_outcome(status, assigned_counter, ratchet_due);
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Offer one item, idling at random first; valid stays high afterwards.
  task automatic send_item(mode_t m, logic [COUNTER_W-1:0] ctr);
    while ($urandom_range(99) < src_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    mode             <= m;
    received_counter <= ctr;
    do @(posedge clk); while (!in_ready);
    tracker.accept_item(m, ctr);
  endtask

  // Hold the sender until every expected result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Pick a receive counter around the current highest counter.
  function automatic logic [COUNTER_W-1:0] near_counter();
    int pick = $urandom_range(99);
    logic [COUNTER_W-1:0] h = tracker.highest_rx;
    int back = (h < 70) ? int'(h) : 70;
    if (pick < 45) return h + $urandom_range(1, 4);
    if (pick < 82) return h - $urandom_range(0, back);
    if (pick < 92) return h + $urandom_range(60, 70);
    if (pick < 96) return {$urandom, $urandom};
    return pick[0] ? '1 : '0;
  endfunction

  // Mostly well-formed sessions; some noise on closed sessions.
  task automatic random_item();
    int pick = $urandom_range(99);
    logic [COUNTER_W-1:0] junk = {$urandom, $urandom};
    if (!tracker.is_open) begin
      if (pick < 85) send_item(MODE_OPEN, junk);
      else send_item(mode_t'($urandom_range(3)), junk);
    end else if (pick < 2) begin
      send_item(MODE_CLOSE, junk);
    end else if (pick < 4) begin
      send_item(MODE_OPEN, junk);
    end else if (pick < 40) begin
      send_item(MODE_SEND, junk);
    end else begin
      send_item(MODE_RECV, near_counter());
    end
  endtask

  task automatic run_phase(logic en, logic [CFG_DATA_W-1:0] every, int idle, int stall);
    logic [CFG_DATA_W-1:0] en_word = $urandom;
    drain();
    en_word[0] = en;
    write_reg(CFG_RATCHET_ENABLE, en_word);
    write_reg(CFG_RATCHET_PERIOD, every);
    settings++;
    src_idle  = idle;
    stall_pct = stall;
    for (int i = 0; i < 235; i++) begin
      // Let the pipeline empty once mid-phase.
      if (i == 117) drain();
      random_item();
    end
  endtask

  initial begin
    tracker = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: closed-session traffic, window edges, counter extremes.
    send_item(MODE_SEND, '1);
    send_item(MODE_RECV, '0);
    send_item(MODE_CLOSE, '0);
    send_item(MODE_OPEN, '1);
    send_item(MODE_RECV, 64'd0);
    send_item(MODE_RECV, 64'd0);
    send_item(MODE_RECV, 64'd63);
    send_item(MODE_RECV, 64'd0);
    send_item(MODE_RECV, 64'd0);
    send_item(MODE_RECV, 64'd64);
    send_item(MODE_RECV, 64'd0);
    send_item(MODE_RECV, 64'd1);
    send_item(MODE_RECV, 64'd200);
    send_item(MODE_RECV, 64'd200);
    send_item(MODE_RECV, '1);
    send_item(MODE_RECV, 64'd0);
    send_item(MODE_SEND, 64'h5555_5555_5555_5555);
    send_item(MODE_SEND, 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(MODE_SEND, '0);
    send_item(MODE_CLOSE, '1);
    send_item(MODE_SEND, '0);
    send_item(MODE_OPEN, '0);
    send_item(MODE_SEND, '0);

    // Random phases over several register settings and idle patterns.
    run_phase(1'b1, 32'd1, 0, 0);
    run_phase(1'b1, 32'd3, 71, 0);
    run_phase(1'b0, 32'd2, 0, 71);
    run_phase(1'b1, 32'hFFFF_FFFF, 33, 33);
    run_phase(1'b1, 32'd0, 0, 0);
    drain();
    write_reg(CFG_SPARE_IDX, $urandom);
    run_phase(1'b1, $urandom_range(2, 16), 33, 33);
    run_phase(1'b0, $urandom, 71, 71);
    run_phase(1'b1, 32'd5, 0, 71);

    drain();
    repeat (4) @(posedge clk);
    $display("Ran %0d items over %0d register settings: %0d sends, %0d receives,",
             tracker.items, settings, tracker.n_send, tracker.n_recv);
    $display("  %0d replays rejected, %0d ratchets due, %0d on closed sessions",
             tracker.n_replay, tracker.n_ratchet, tracker.n_closed);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("session_counter_replay_window_unit test passed");
    end else begin
      $display("session_counter_replay_window_unit test failed");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding", tracker.pending());
    $display("session_counter_replay_window_unit test failed");
    $finish;
  end

endmodule
